### design/plen_pkg.sv
// Shared constants, types and helpers for the positional list engine.
`default_nettype none

package plen_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = ((LEN_W > 8) ? LEN_W : 8) + 1;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int ELEM_W   = 32;
    localparam int EIDX_W   = 5;
    localparam int COUNT_W  = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_DUMP      = 3'd6,
        OP_NOP       = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;
        logic dump_step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_valid;
        logic dump_multi;
        logic dump_at_last;
    } sts_t;

    function automatic logic [COUNT_W-1:0] to_field5(input logic [63:0] x);
        to_field5 = x[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/plen_ctrl.sv
// Controller state machine: sequences operations and dump transactions.
`default_nettype none

module plen_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           out_stall,
    input  wire plen_pkg::sts_t sts,
    output plen_pkg::cmd_t      cmd,
    output logic                in_stall
);

    plen_pkg::state_t state_reg;
    plen_pkg::state_t state_next;
    logic             can_load;

    assign can_load = !sts.out_valid || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plen_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.exec      = 1'b0;
        cmd.dump_step = 1'b0;
        in_stall      = 1'b1;
        unique case (state_reg)
            plen_pkg::S_IDLE:
            begin
                in_stall = !can_load;
                cmd.exec = in_valid && can_load;
                if (cmd.exec && sts.dump_multi)
                begin
                    state_next = plen_pkg::S_DUMP;
                end
            end
            plen_pkg::S_DUMP:
            begin
                cmd.dump_step = can_load;
                if (can_load && sts.dump_at_last)
                begin
                    state_next = plen_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plen_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/plen_dp.sv
// Datapath: shifting cells, element count, dump index and output register.
`default_nettype none

module plen_dp
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [plen_pkg::OPCODE_W-1:0]       opcode,
    input  wire logic [plen_pkg::VALUE_W-1:0]        value,
    input  wire logic [plen_pkg::POS_W-1:0]          position,
    input  wire plen_pkg::cmd_t                      cmd,
    input  wire logic                                out_stall,
    output plen_pkg::sts_t                           sts,
    output logic                                     out_valid,
    output logic [plen_pkg::STATUS_W-1:0]            status,
    output logic [plen_pkg::ELEM_W-1:0]              element,
    output logic [plen_pkg::EIDX_W-1:0]              element_index,
    output logic [plen_pkg::COUNT_W-1:0]             count,
    output logic                                     is_empty,
    output logic                                     last
);

    localparam int CAP   = plen_pkg::CAPACITY;
    localparam int DW    = plen_pkg::DATA_WIDTH;
    localparam int LEN_W = plen_pkg::LEN_W;
    localparam int IDX_W = plen_pkg::IDX_W;
    localparam int CMP_W = plen_pkg::CMP_W;

    logic [DW-1:0]    cells_reg [CAP];
    logic [DW-1:0]    cells_next [CAP];
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    plen_pkg::status_t          status_reg;
    plen_pkg::status_t          status_next;
    logic [plen_pkg::ELEM_W-1:0]  element_reg;
    logic [plen_pkg::ELEM_W-1:0]  element_next;
    logic [plen_pkg::EIDX_W-1:0]  eidx_reg;
    logic [plen_pkg::EIDX_W-1:0]  eidx_next;
    logic [plen_pkg::COUNT_W-1:0] count_reg;
    logic [plen_pkg::COUNT_W-1:0] count_next;
    logic                       empty_reg;
    logic                       empty_next;
    logic                       last_reg;
    logic                       last_next;

    plen_pkg::opcode_t op;
    plen_pkg::status_t op_status;
    logic [CMP_W-1:0]  len_c;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  at_c;
    logic              ins_req;
    logic              del_req;
    logic              list_full;
    logic              list_empty;
    logic              do_ins;
    logic              do_del;
    logic [63:0]       value_wide;
    logic [DW-1:0]     ins_data;
    logic [63:0]       head_wide;
    logic [63:0]       sel_wide;

    assign op         = plen_pkg::opcode_t'(opcode);
    assign len_c      = CMP_W'(length_reg);
    assign pos_c      = CMP_W'(position);
    assign list_full  = (length_reg == LEN_W'(CAP));
    assign list_empty = (length_reg == '0);
    assign value_wide = 64'(value);
    assign ins_data   = value_wide[DW-1:0];
    assign head_wide  = 64'(cells_reg[0]);
    assign sel_wide   = 64'(cells_reg[idx_reg]);

    // Decode the operation: where it acts and whether it is legal.
    always_comb
    begin
        ins_req   = 1'b0;
        del_req   = 1'b0;
        at_c      = '0;
        op_status = plen_pkg::ST_DONE;
        unique case (op) inside
            plen_pkg::OP_INS_FRONT:
            begin
                ins_req = 1'b1;
            end
            plen_pkg::OP_INS_BACK:
            begin
                ins_req = 1'b1;
                at_c    = len_c;
            end
            plen_pkg::OP_INS_POS:
            begin
                if (pos_c == '0 || pos_c > len_c + CMP_W'(1))
                begin
                    op_status = plen_pkg::ST_RANGE;
                end
                else
                begin
                    ins_req = 1'b1;
                    at_c    = pos_c - CMP_W'(1);
                end
            end
            plen_pkg::OP_DEL_FRONT:
            begin
                if (list_empty)
                begin
                    op_status = plen_pkg::ST_EMPTY;
                end
                else
                begin
                    del_req = 1'b1;
                end
            end
            plen_pkg::OP_DEL_BACK:
            begin
                if (list_empty)
                begin
                    op_status = plen_pkg::ST_EMPTY;
                end
                else
                begin
                    del_req = 1'b1;
                    at_c    = len_c - CMP_W'(1);
                end
            end
            plen_pkg::OP_DEL_POS:
            begin
                if (list_empty)
                begin
                    op_status = plen_pkg::ST_EMPTY;
                end
                else if (pos_c == '0 || pos_c > len_c)
                begin
                    op_status = plen_pkg::ST_RANGE;
                end
                else
                begin
                    del_req = 1'b1;
                    at_c    = pos_c - CMP_W'(1);
                end
            end
            plen_pkg::OP_DUMP,
            plen_pkg::OP_NOP:
            begin
                op_status = plen_pkg::ST_DONE;
            end
            default:
            begin
                op_status = plen_pkg::ST_DONE;
            end
        endcase
        if (ins_req && list_full)
        begin
            op_status = plen_pkg::ST_FULL;
        end
    end

    assign do_ins = cmd.exec && ins_req && !list_full;
    assign do_del = cmd.exec && del_req;

    // Each cell picks from itself, its lower or upper neighbor, or the new value.
    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        always_comb
        begin
            cells_next[g] = cells_reg[g];
            if (do_ins)
            begin
                if (CMP_W'(g) == at_c)
                begin
                    cells_next[g] = ins_data;
                end
                else if (g > 0 && CMP_W'(g) > at_c)
                begin
                    cells_next[g] = cells_reg[(g > 0) ? g - 1 : 0];
                end
            end
            else if (do_del)
            begin
                if (g < CAP - 1 && CMP_W'(g) >= at_c)
                begin
                    cells_next[g] = cells_reg[(g < CAP - 1) ? g + 1 : g];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAP; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
    end

    always_comb
    begin
        length_next = length_reg;
        if (do_ins)
        begin
            length_next = length_reg + LEN_W'(1);
        end
        else if (do_del)
        begin
            length_next = length_reg - LEN_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.exec)
        begin
            idx_next = IDX_W'(1);
        end
        else if (cmd.dump_step)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register: load on an operation or a dump step; else hold, valid only under stall.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        element_next   = element_reg;
        eidx_next      = eidx_reg;
        count_next     = count_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
            status_next    = op_status;
            element_next   = '0;
            eidx_next      = '0;
            count_next     = plen_pkg::to_field5(64'(length_next));
            empty_next     = 1'b0;
            last_next      = 1'b1;
            if (op == plen_pkg::OP_DUMP)
            begin
                if (list_empty)
                begin
                    empty_next = 1'b1;
                end
                else
                begin
                    element_next = head_wide[plen_pkg::ELEM_W-1:0];
                    eidx_next    = plen_pkg::to_field5(64'd1);
                    last_next    = (length_reg == LEN_W'(1));
                end
            end
        end
        else if (cmd.dump_step)
        begin
            out_valid_next = 1'b1;
            status_next    = plen_pkg::ST_DONE;
            element_next   = sel_wide[plen_pkg::ELEM_W-1:0];
            eidx_next      = plen_pkg::to_field5(64'(idx_reg) + 64'd1);
            count_next     = plen_pkg::to_field5(64'(length_reg));
            empty_next     = 1'b0;
            last_next      = sts.dump_at_last;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        eidx_reg    <= eidx_next;
        count_reg   <= count_next;
        empty_reg   <= empty_next;
        last_reg    <= last_next;
    end

    assign sts.out_valid    = out_valid_reg;
    assign sts.dump_multi   = (op == plen_pkg::OP_DUMP) && (length_reg > LEN_W'(1));
    assign sts.dump_at_last = ((CMP_W'(idx_reg) + CMP_W'(1)) == len_c);

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element       = element_reg;
    assign element_index = eidx_reg;
    assign count         = count_reg;
    assign is_empty      = empty_reg;
    assign last          = last_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LEN_W'(CAP))
        else $error("element count exceeds capacity");

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_step |-> !cmd.exec)
        else $error("dump step and new operation in the same cycle");

    a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_step |-> (CMP_W'(idx_reg) < len_c))
        else $error("dump index past the end of the list");

    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> (length_reg == $past(length_reg) + LEN_W'(1)))
        else $error("insert did not grow the list");

    a_dump_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_step |=> $stable(length_reg))
        else $error("list changed during a dump");

endmodule

`default_nettype wire

### design/positional_list_engine_core.sv
// Top level of the positional list engine: controller plus datapath.
`default_nettype none

//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  input    | in_valid / in_stall       | opcode, value, position
//  output   | out_valid / out_stall     | status, element, element_index, count,
//           |                           | is_empty, last
//
// Insert, delete and no-op: all cells pick their next value in
// parallel, so the list is updated in the accept cycle. A dump of n elements
// gives n transactions, cell 0 first, then the single read mux on the cells,
// with the input stalled after the first; an empty dump gives one transaction.
// Reset (rst_n low, asynchronous) empties the list; cell contents are not cleared.
// The output register reloads in the cycle its transaction is taken; while a
// result waits under out_stall, hold in_stall high.

module positional_list_engine_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [plen_pkg::OPCODE_W-1:0]  opcode,
    input  wire logic [plen_pkg::VALUE_W-1:0]   value,
    input  wire logic [plen_pkg::POS_W-1:0]     position,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [plen_pkg::STATUS_W-1:0]       status,
    output logic [plen_pkg::ELEM_W-1:0]         element,
    output logic [plen_pkg::EIDX_W-1:0]         element_index,
    output logic [plen_pkg::COUNT_W-1:0]        count,
    output logic                                is_empty,
    output logic                                last
);

    // Command and status between the sequencer and the datapath.
    plen_pkg::cmd_t cmd;
    plen_pkg::sts_t sts;

    // Sequencer: accept a transaction, or advance a dump one element.
    plen_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    // Datapath: shift cells on insert/delete, hold the count, drive results.
    plen_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .value         (value),
        .position      (position),
        .cmd           (cmd),
        .out_stall     (out_stall),
        .sts           (sts),
        .out_valid     (out_valid),
        .status        (status),
        .element       (element),
        .element_index (element_index),
        .count         (count),
        .is_empty      (is_empty),
        .last          (last)
    );

endmodule

`default_nettype wire
